### rtl/crq_pkg.sv
package crq_pkg;

    // packed command word layout
    localparam int WORD_W     = 16;
    localparam int ID_SHIFT   = 12;
    localparam int CODE_SHIFT = 8;
    localparam int ID_W       = 4;
    localparam int CODE_W     = 4;
    localparam int AMOUNT_W   = 8;
    localparam logic [AMOUNT_W-1:0] AMOUNT_MASK = 8'hff;

    // request codes
    localparam logic [1:0] CMD_PUSH  = 2'd0;
    localparam logic [1:0] CMD_POP   = 2'd1;
    localparam logic [1:0] CMD_FLUSH = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_CLOSE_A = 2'd0;
    localparam logic [1:0] CFG_CLOSE_B = 2'd1;
    localparam logic [1:0] CFG_CLOSE_C = 2'd2;

    localparam logic [CODE_W-1:0] CLOSE_A_RST = 4'd1;
    localparam logic [CODE_W-1:0] CLOSE_B_RST = 4'd2;
    localparam logic [CODE_W-1:0] CLOSE_C_RST = 4'd3;

    // write request into the entry store
    typedef struct packed {
        logic                 en;
        logic [WORD_W-1:0]    data;
    } t_wr_req;

endpackage

### rtl/crq_store.sv
module crq_store #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  logic                           i_clk,
    input  crq_pkg::t_wr_req               i_wr,
    input  logic [ADDR_W-1:0]              i_waddr,
    input  logic [ADDR_W-1:0]              i_raddr,
    output logic [crq_pkg::WORD_W-1:0]     o_rdata
);

    logic [crq_pkg::WORD_W-1:0] r_mem [DEPTH];
    logic [crq_pkg::WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_waddr] <= i_wr.data;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/command_ring_queue_with_cancel_unit.sv
// Ring queue of 16-bit command words (unit id 15..12, code 11..8, amount 7..0)
// with cancel by unit. Each accepted request gives exactly one result. A pop
// that removes an entry reads the oldest word in ST_POP and then waits in
// ST_DONE; a flush, a refused push, a pop on an empty queue or an unused
// command goes straight to ST_DONE; a plain push passes through ST_APPEND.
// A push whose code equals one of the three close codes walks every queued
// entry through the single store read port and zeroes those of the same unit
// in ST_WALK before it appends; such a walk only runs when at least one slot
// is free. The input is stalled while a request is at work; a finished result
// sits in the output register and the next request may be accepted while it
// waits. The store is not cleared at reset: only written entries are ever read.
module command_ring_queue_with_cancel_unit #(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // request channel
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [1:0]                       i_command,
    input  logic [crq_pkg::ID_W-1:0]         i_unit_id,
    input  logic [crq_pkg::CODE_W-1:0]       i_control_code,
    input  logic [crq_pkg::AMOUNT_W-1:0]     i_amount,
    // result channel
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [crq_pkg::WORD_W-1:0]       o_entry_word,
    output logic                             o_entry_taken,
    output logic                             o_entry_cancelled,
    output logic                             o_queue_empty,
    output logic                             o_overflow,
    // configuration write channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [1:0]                       i_cfg_index,
    input  logic [crq_pkg::CODE_W-1:0]       i_cfg_data
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(QUEUE_DEPTH - 1);
    localparam logic [FW-1:0] FULL_CNT  = FW'(QUEUE_DEPTH);

    // sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_WALK   = 3'd1;
    localparam logic [2:0] ST_APPEND = 3'd2;
    localparam logic [2:0] ST_POP    = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] p);
        next_slot = (p == LAST_SLOT) ? '0 : p + 1'b1;
    endfunction

    // control state
    logic [2:0]                  r_state, n_state;
    logic [AW-1:0]               r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]               r_rd_ptr, n_rd_ptr;
    logic [FW-1:0]               r_fill, n_fill;
    logic [AW-1:0]               r_walk_ptr, n_walk_ptr;
    logic [FW-1:0]               r_walk_left, n_walk_left;
    logic                        r_chk_vld, n_chk_vld;
    logic                        r_out_valid, n_out_valid;
    logic [crq_pkg::CODE_W-1:0]  r_close_a, r_close_b, r_close_c;

    // payload state
    logic [AW-1:0]               r_chk_addr, n_chk_addr;
    logic [crq_pkg::WORD_W-1:0]  r_word, n_word;
    logic [crq_pkg::WORD_W-1:0]  r_res_word, n_res_word;
    logic                        r_res_taken, n_res_taken;
    logic                        r_res_cancel, n_res_cancel;
    logic                        r_res_empty, n_res_empty;
    logic                        r_res_ovf, n_res_ovf;
    logic [crq_pkg::WORD_W-1:0]  r_o_word;
    logic                        r_o_taken, r_o_cancel, r_o_empty, r_o_ovf;

    // store access
    crq_pkg::t_wr_req            wr_req;
    logic [AW-1:0]               waddr;
    logic [AW-1:0]               raddr;
    logic [crq_pkg::WORD_W-1:0]  rdata;

    logic                        in_acc;
    logic                        is_close;
    logic                        out_free;
    logic                        load_out;

    crq_store #(
        .DEPTH  (QUEUE_DEPTH),
        .ADDR_W (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_wr    (wr_req),
        .i_waddr (waddr),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_acc      = i_in_valid && (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign is_close    = (i_control_code == r_close_a) || (i_control_code == r_close_b)
                      || (i_control_code == r_close_c);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign load_out    = (r_state == ST_DONE) && out_free;

    // read port: walk address during a cancel, else the oldest entry (so a
    // pop finds its word registered in the cycle after acceptance)
    assign raddr = (r_state == ST_WALK) ? r_walk_ptr : r_rd_ptr;

    always_comb begin
        n_state      = r_state;
        n_wr_ptr     = r_wr_ptr;
        n_rd_ptr     = r_rd_ptr;
        n_fill       = r_fill;
        n_walk_ptr   = r_walk_ptr;
        n_walk_left  = r_walk_left;
        n_chk_vld    = 1'b0;
        n_chk_addr   = r_chk_addr;
        n_word       = r_word;
        n_res_word   = r_res_word;
        n_res_taken  = r_res_taken;
        n_res_cancel = r_res_cancel;
        n_res_empty  = r_res_empty;
        n_res_ovf    = r_res_ovf;
        n_out_valid  = r_out_valid;
        wr_req.en    = 1'b0;
        wr_req.data  = r_word;
        waddr        = r_wr_ptr;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_word = (crq_pkg::WORD_W'(i_unit_id) << crq_pkg::ID_SHIFT)
                           | (crq_pkg::WORD_W'(i_control_code) << crq_pkg::CODE_SHIFT)
                           | crq_pkg::WORD_W'(i_amount & crq_pkg::AMOUNT_MASK);
                    n_res_word   = '0;
                    n_res_taken  = 1'b0;
                    n_res_cancel = 1'b0;
                    n_res_ovf    = 1'b0;
                    n_res_empty  = (r_fill == '0);
                    n_state      = ST_DONE;
                    case (i_command)
                        crq_pkg::CMD_PUSH: begin
                            if (r_fill == FULL_CNT) begin
                                n_res_ovf = 1'b1;
                            end else if (is_close && (r_fill != '0)) begin
                                n_walk_ptr  = r_rd_ptr;
                                n_walk_left = r_fill;
                                n_state     = ST_WALK;
                            end else begin
                                n_state = ST_APPEND;
                            end
                        end
                        crq_pkg::CMD_POP: begin
                            if (r_fill != '0) begin
                                n_state = ST_POP;
                            end
                        end
                        crq_pkg::CMD_FLUSH: begin
                            n_wr_ptr    = '0;
                            n_rd_ptr    = '0;
                            n_fill      = '0;
                            n_res_empty = 1'b1;
                        end
                        default: begin
                            // unused code: report state only
                        end
                    endcase
                end
            end
            ST_WALK: begin
                // read one entry a cycle, check and zero the one read last cycle
                if (r_walk_left != '0) begin
                    n_walk_ptr  = next_slot(r_walk_ptr);
                    n_walk_left = r_walk_left - 1'b1;
                    n_chk_vld   = 1'b1;
                    n_chk_addr  = r_walk_ptr;
                end
                if (r_chk_vld && (rdata[crq_pkg::WORD_W-1:crq_pkg::ID_SHIFT]
                                  == r_word[crq_pkg::WORD_W-1:crq_pkg::ID_SHIFT])) begin
                    wr_req.en   = 1'b1;
                    wr_req.data = '0;
                    waddr       = r_chk_addr;
                end
                if ((r_walk_left == '0) && !r_chk_vld) begin
                    n_state = ST_APPEND;
                end
            end
            ST_APPEND: begin
                wr_req.en   = 1'b1;
                n_wr_ptr    = next_slot(r_wr_ptr);
                n_fill      = r_fill + 1'b1;
                n_res_empty = 1'b0;
                n_state     = ST_DONE;
            end
            ST_POP: begin
                n_res_word   = rdata;
                n_res_taken  = 1'b1;
                n_res_cancel = (rdata == '0);
                n_rd_ptr     = next_slot(r_rd_ptr);
                n_fill       = r_fill - 1'b1;
                n_res_empty  = (r_fill == FW'(1));
                n_state      = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_fill      <= '0;
            r_walk_ptr  <= '0;
            r_walk_left <= '0;
            r_chk_vld   <= 1'b0;
            r_out_valid <= 1'b0;
            r_close_a   <= crq_pkg::CLOSE_A_RST;
            r_close_b   <= crq_pkg::CLOSE_B_RST;
            r_close_c   <= crq_pkg::CLOSE_C_RST;
        end else begin
            r_state     <= n_state;
            r_wr_ptr    <= n_wr_ptr;
            r_rd_ptr    <= n_rd_ptr;
            r_fill      <= n_fill;
            r_walk_ptr  <= n_walk_ptr;
            r_walk_left <= n_walk_left;
            r_chk_vld   <= n_chk_vld;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    crq_pkg::CFG_CLOSE_A: r_close_a <= i_cfg_data;
                    crq_pkg::CFG_CLOSE_B: r_close_b <= i_cfg_data;
                    crq_pkg::CFG_CLOSE_C: r_close_c <= i_cfg_data;
                    default: begin
                        // write beyond the register list is dropped
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_chk_addr   <= n_chk_addr;
        r_word       <= n_word;
        r_res_word   <= n_res_word;
        r_res_taken  <= n_res_taken;
        r_res_cancel <= n_res_cancel;
        r_res_empty  <= n_res_empty;
        r_res_ovf    <= n_res_ovf;
        if (load_out) begin
            r_o_word   <= r_res_word;
            r_o_taken  <= r_res_taken;
            r_o_cancel <= r_res_cancel;
            r_o_empty  <= r_res_empty;
            r_o_ovf    <= r_res_ovf;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_entry_word      = r_o_word;
    assign o_entry_taken     = r_o_taken;
    assign o_entry_cancelled = r_o_cancel;
    assign o_queue_empty     = r_o_empty;
    assign o_overflow        = r_o_ovf;

endmodule
